// ===== hw/rtl/ivmc_pkg.sv =====
// Package for the IR volume multi-channel controller core.
// Holds input mode codes, register indexes, direction codes and Q15 constants.
// No dependencies.
`default_nettype none

package ivmc_pkg;

	// input modes (s_axis_tuser)
	localparam logic [2:0] MODE_TICK  = 3'd0;
	localparam logic [2:0] MODE_IR    = 3'd1;
	localparam logic [2:0] MODE_ENC   = 3'd2;
	localparam logic [2:0] MODE_NEXT  = 3'd3;
	localparam logic [2:0] MODE_START = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_POT_COUNT  = 3'd0;
	localparam logic [2:0] REG_BASE_STEP  = 3'd1;
	localparam logic [2:0] REG_DEF_TO     = 3'd2;
	localparam logic [2:0] REG_SHUT_TO    = 3'd3;
	localparam logic [2:0] REG_UP_CODES   = 3'd4;
	localparam logic [2:0] REG_DOWN_CODES = 3'd5;
	localparam logic [2:0] REG_INIT_LVL   = 3'd6;

	// direction codes
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd3;

	localparam logic [15:0] Q15_ONE     = 16'h8000;
	localparam logic [15:0] REPEAT_CODE = 16'hFFFF;
	localparam logic [15:0] REPEAT_MAX  = 16'hFFFF;
	localparam logic [3:0]  REPEAT_WRAP = 4'd9;   // repeat period minus one
	localparam logic [2:0]  FAST_FACTOR = 3'd5;
	localparam int          MAX_RES     = 4;

	// register reset values
	localparam logic [2:0]  POT_RESET  = 3'd4;
	localparam logic [15:0] BASE_RESET = 16'd328;
	localparam logic [31:0] DEF_RESET  = 32'd5000;
	localparam logic [31:0] SHUT_RESET = 32'd10000;

endpackage

`default_nettype wire

// ===== hw/rtl/ir_volume_multi_channel_controller_core.sv =====
// IR volume multi-channel controller core: top level with sequencer and level unit.
// Depends on ivmc_pkg.
//
// Takes one input word at a time (s_axis_tready is high only while idle) and
// writes its results into a four-entry buffer, then drains them one word per
// cycle, unless the output side stalls, into the output register. Every level
// change, timer report and start report passes through one shared add-and-clamp
// unit, one result per cycle. After acceptance an encoder step or select-next makes
// one level update, a repeat a step then a level update, a tick a default then a
// shut timer check, an IR code scan one channel compare at a time and a start a
// level load then an update per channel in use, none with no channel in use; an
// unused mode does no work. Results then drain and the core returns to idle. The
// output register lets the next word in while the final result is still waiting to be taken.
`default_nettype none

module ir_volume_multi_channel_controller_core #(
	parameter int CHANNELS       = 4,
	parameter int PWM_FULL_SCALE = 768
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	// input words
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // ir_code[15:0], step[31:16]
	input  wire logic [2:0]  s_axis_tuser,  // mode[2:0]
	// result words
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // channel[1:0], level[17:2], pwm_level[27:18],
	                                        // selected[29:28], zero[31:30]
	output logic [0:0]       m_axis_tuser,  // ring_off[0]
	output logic             m_axis_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK_D,
		ST_TICK_S,
		ST_SCAN,
		ST_REP,
		ST_START,
		ST_LEVEL,
		ST_EMIT
	} state_t;

	localparam int MAX_RES_L = ivmc_pkg::MAX_RES;

	state_t state_q;

	// configuration
	logic [2:0]  pot_q;
	logic [15:0] base_q;
	logic [31:0] def_to_q;
	logic [31:0] shut_to_q;
	logic [63:0] up_q;
	logic [63:0] down_q;
	logic [63:0] init_q;

	// controller state
	logic [15:0] lvl_q [CHANNELS];
	logic [1:0]  sel_q;
	logic [1:0]  dir_q;
	logic [15:0] cur_q;
	logic [15:0] rc_q;
	logic [3:0]  mod_q;
	logic [31:0] def_rem_q;
	logic [31:0] shut_rem_q;
	logic        def_run_q;
	logic        shut_run_q;

	// sequencer working registers
	logic [15:0]        code_q;
	logic [2:0]         idx_q;
	logic [1:0]         ch_q;
	logic signed [16:0] inc_q;
	logic               start_q;

	// result buffer
	logic [1:0]  rbuf_ch_q  [MAX_RES_L];
	logic [15:0] rbuf_lvl_q [MAX_RES_L];
	logic        rbuf_off_q [MAX_RES_L];
	logic [2:0]  res_n_q;
	logic [2:0]  rd_q;

	// output register
	logic        m_valid_q;
	logic [1:0]  m_ch_q;
	logic [15:0] m_lvl_q;
	logic [9:0]  m_pwm_q;
	logic        m_off_q;
	logic [1:0]  m_sel_q;
	logic        m_last_q;

	function automatic logic [15:0] sat_q15(input logic [15:0] v);
		return (v > ivmc_pkg::Q15_ONE) ? ivmc_pkg::Q15_ONE : v;
	endfunction

	// active channel count
	logic [2:0] cnt;
	logic [2:0] cfg_cnt;
	assign cnt     = (32'(pot_q) < CHANNELS) ? pot_q : 3'(CHANNELS);
	assign cfg_cnt = (32'(cfg_data[2:0]) < CHANNELS) ? cfg_data[2:0] : 3'(CHANNELS);

	// shared level unit
	logic [1:0]         unit_ch;
	logic signed [16:0] unit_inc;
	logic [15:0]        lvl_rd;
	logic [15:0]        lvl_sat;
	logic signed [17:0] unit_sum;
	logic [15:0]        unit_res;

	always_comb begin
		case (state_q)
			ST_TICK_D: unit_ch = 2'd0;
			ST_TICK_S: unit_ch = sel_q;
			default:   unit_ch = ch_q;
		endcase
	end

	assign unit_inc = (state_q == ST_LEVEL) ? inc_q : 17'sd0;

	always_comb begin
		lvl_rd = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (unit_ch == 2'(i)) lvl_rd = lvl_q[i];
		end
	end

	assign lvl_sat  = sat_q15(lvl_rd);
	assign unit_sum = $signed({2'b00, lvl_sat}) + $signed({unit_inc[16], unit_inc});

	always_comb begin
		if (unit_sum < 18'sd0) begin
			unit_res = '0;
		end else if (unit_sum > $signed({2'b00, ivmc_pkg::Q15_ONE})) begin
			unit_res = ivmc_pkg::Q15_ONE;
		end else begin
			unit_res = unit_sum[15:0];
		end
	end

	// repeat step growth
	logic [18:0]        fast_sum;
	logic [15:0]        cur_next;
	logic signed [16:0] rep_inc;
	logic [15:0]        base_sat;

	assign base_sat = sat_q15(base_q);
	assign fast_sum = 19'(cur_q) + 19'(base_q) * 19'(ivmc_pkg::FAST_FACTOR);

	always_comb begin
		if (rc_q > 16'd1 && mod_q == 4'd0) begin
			cur_next = (fast_sum > 19'(ivmc_pkg::Q15_ONE)) ? ivmc_pkg::Q15_ONE : fast_sum[15:0];
		end else begin
			cur_next = cur_q;
		end
		case (dir_q)
			ivmc_pkg::DIR_UP:   rep_inc = $signed({1'b0, cur_next});
			ivmc_pkg::DIR_DOWN: rep_inc = 17'sd0 - $signed({1'b0, cur_next});
			default:            rep_inc = 17'sd0;
		endcase
	end

	// IR code compare, one channel per cycle
	logic up_hit;
	logic down_hit;
	assign up_hit   = (code_q == up_q[idx_q[1:0] * 16 +: 16]);
	assign down_hit = (code_q == down_q[idx_q[1:0] * 16 +: 16]);

	// select-next channel
	logic [1:0] sel_nxt;
	assign sel_nxt = (({1'b0, sel_q} + 3'd1) >= cnt) ? 2'd0 : sel_q + 2'd1;

	// PWM of the result being drained
	logic [27:0] pwm_prod;
	logic [27:0] pwm_rnd;
	assign pwm_prod = 28'(rbuf_lvl_q[rd_q[1:0]]) * 28'(PWM_FULL_SCALE);
	assign pwm_rnd  = pwm_prod + 28'(ivmc_pkg::Q15_ONE >> 1);

	// output register load
	logic emit_go;
	assign emit_go = (state_q == ST_EMIT) && (rd_q != res_n_q)
	                 && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pot_q      <= ivmc_pkg::POT_RESET;
			base_q     <= ivmc_pkg::BASE_RESET;
			def_to_q   <= ivmc_pkg::DEF_RESET;
			shut_to_q  <= ivmc_pkg::SHUT_RESET;
			up_q       <= '0;
			down_q     <= '0;
			init_q     <= '0;
			for (int i = 0; i < CHANNELS; i++) lvl_q[i] <= '0;
			sel_q      <= '0;
			dir_q      <= ivmc_pkg::DIR_NONE;
			cur_q      <= ivmc_pkg::BASE_RESET;
			rc_q       <= '0;
			mod_q      <= '0;
			def_rem_q  <= '0;
			shut_rem_q <= '0;
			def_run_q  <= 1'b0;
			shut_run_q <= 1'b0;
			code_q     <= '0;
			idx_q      <= '0;
			ch_q       <= '0;
			inc_q      <= '0;
			start_q    <= 1'b0;
			res_n_q    <= '0;
			rd_q       <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					ivmc_pkg::REG_POT_COUNT: begin
						pot_q <= cfg_data[2:0];
						if ({1'b0, sel_q} >= cfg_cnt) sel_q <= '0;
					end
					ivmc_pkg::REG_BASE_STEP:  base_q    <= cfg_data[15:0];
					ivmc_pkg::REG_DEF_TO:     def_to_q  <= cfg_data[31:0];
					ivmc_pkg::REG_SHUT_TO:    shut_to_q <= cfg_data[31:0];
					ivmc_pkg::REG_UP_CODES:   up_q      <= cfg_data;
					ivmc_pkg::REG_DOWN_CODES: down_q    <= cfg_data;
					ivmc_pkg::REG_INIT_LVL:   init_q    <= cfg_data;
					default: ;
				endcase
			end

			if (m_axis_tready && !emit_go) m_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						res_n_q <= '0;
						rd_q    <= '0;
						start_q <= 1'b0;
						case (s_axis_tuser)
							ivmc_pkg::MODE_TICK: state_q <= ST_TICK_D;
							ivmc_pkg::MODE_IR: begin
								code_q  <= s_axis_tdata[15:0];
								idx_q   <= '0;
								state_q <= (s_axis_tdata[15:0] == ivmc_pkg::REPEAT_CODE)
								           ? ST_REP : ST_SCAN;
							end
							ivmc_pkg::MODE_ENC: begin
								ch_q    <= sel_q;
								inc_q   <= $signed({s_axis_tdata[31], s_axis_tdata[31:16]});
								state_q <= (cnt != 3'd0) ? ST_LEVEL : ST_EMIT;
							end
							ivmc_pkg::MODE_NEXT: begin
								if (cnt != 3'd0) begin
									sel_q   <= sel_nxt;
									ch_q    <= sel_nxt;
									inc_q   <= 17'sd0;
									state_q <= ST_LEVEL;
								end else begin
									state_q <= ST_EMIT;
								end
							end
							ivmc_pkg::MODE_START: state_q <= ST_START;
							default: state_q <= ST_EMIT;
						endcase
					end
				end

				ST_TICK_D: begin
					if (def_run_q) begin
						if (def_rem_q <= 32'd1) begin
							def_rem_q <= '0;
							def_run_q <= 1'b0;
							if (cnt != 3'd0) begin
								sel_q                       <= '0;
								rbuf_ch_q[res_n_q[1:0]]  <= 2'd0;
								rbuf_lvl_q[res_n_q[1:0]] <= unit_res;
								rbuf_off_q[res_n_q[1:0]] <= 1'b0;
								res_n_q                     <= res_n_q + 3'd1;
							end
						end else begin
							def_rem_q <= def_rem_q - 32'd1;
						end
					end
					state_q <= ST_TICK_S;
				end

				ST_TICK_S: begin
					if (shut_run_q) begin
						if (shut_rem_q <= 32'd1) begin
							shut_rem_q <= '0;
							shut_run_q <= 1'b0;
							if (cnt != 3'd0) begin
								rbuf_ch_q[res_n_q[1:0]]  <= sel_q;
								rbuf_lvl_q[res_n_q[1:0]] <= unit_res;
								rbuf_off_q[res_n_q[1:0]] <= 1'b1;
								res_n_q                     <= res_n_q + 3'd1;
							end
						end else begin
							shut_rem_q <= shut_rem_q - 32'd1;
						end
					end
					state_q <= ST_EMIT;
				end

				ST_SCAN: begin
					if (idx_q >= cnt) begin
						state_q <= ST_EMIT;
					end else if (up_hit || down_hit) begin
						sel_q   <= idx_q[1:0];
						ch_q    <= idx_q[1:0];
						rc_q    <= '0;
						mod_q   <= '0;
						cur_q   <= base_sat;
						dir_q   <= up_hit ? ivmc_pkg::DIR_UP : ivmc_pkg::DIR_DOWN;
						inc_q   <= up_hit ? $signed({1'b0, base_sat})
						                  : 17'sd0 - $signed({1'b0, base_sat});
						state_q <= ST_LEVEL;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end

				ST_REP: begin
					cur_q <= cur_next;
					if (rc_q != ivmc_pkg::REPEAT_MAX) begin
						rc_q  <= rc_q + 16'd1;
						mod_q <= (mod_q == ivmc_pkg::REPEAT_WRAP) ? 4'd0 : mod_q + 4'd1;
					end
					ch_q    <= sel_q;
					inc_q   <= rep_inc;
					state_q <= (cnt != 3'd0) ? ST_LEVEL : ST_EMIT;
				end

				ST_START: begin
					for (int i = 0; i < CHANNELS; i++) begin
						lvl_q[i] <= sat_q15(init_q[i * 16 +: 16]);
					end
					sel_q     <= '0;
					dir_q     <= ivmc_pkg::DIR_NONE;
					rc_q      <= '0;
					mod_q     <= '0;
					cur_q     <= base_sat;
					def_rem_q <= def_to_q;
					def_run_q <= 1'b1;
					ch_q      <= '0;
					inc_q     <= 17'sd0;
					start_q   <= 1'b1;
					state_q   <= (cnt != 3'd0) ? ST_LEVEL : ST_EMIT;
				end

				ST_LEVEL: begin
					for (int i = 0; i < CHANNELS; i++) begin
						if (ch_q == 2'(i)) lvl_q[i] <= unit_res;
					end
					rbuf_ch_q[res_n_q[1:0]]  <= ch_q;
					rbuf_lvl_q[res_n_q[1:0]] <= unit_res;
					rbuf_off_q[res_n_q[1:0]] <= 1'b0;
					res_n_q                     <= res_n_q + 3'd1;
					if (ch_q != 2'd0) begin
						def_rem_q  <= def_to_q;
						def_run_q  <= 1'b1;
						shut_rem_q <= shut_to_q;
						shut_run_q <= 1'b1;
					end
					if (start_q && (({1'b0, ch_q} + 3'd1) < cnt)) begin
						ch_q <= ch_q + 2'd1;
					end else begin
						state_q <= ST_EMIT;
					end
				end

				ST_EMIT: begin
					if (rd_q == res_n_q) begin
						state_q <= ST_IDLE;
					end else if (emit_go) begin
						m_valid_q <= 1'b1;
						m_ch_q    <= rbuf_ch_q[rd_q[1:0]];
						m_lvl_q   <= rbuf_lvl_q[rd_q[1:0]];
						m_pwm_q   <= pwm_rnd[24:15];
						m_off_q   <= rbuf_off_q[rd_q[1:0]];
						m_sel_q   <= sel_q;
						m_last_q  <= ((rd_q + 3'd1) == res_n_q);
						rd_q      <= rd_q + 3'd1;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_sel_q, m_pwm_q, m_lvl_q, m_ch_q};
	assign m_axis_tuser  = m_off_q;
	assign m_axis_tlast  = m_last_q;

	a_sel_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sel_q) < CHANNELS)
		else $error("selection beyond channel count");

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(res_n_q) <= MAX_RES_L && rd_q <= res_n_q)
		else $error("result buffer overrun");

	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && m_valid_q) |-> m_last_q)
		else $error("pending non-last word while idle");

	a_step_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= ivmc_pkg::Q15_ONE)
		else $error("current step above 1.0");

endmodule

`default_nettype wire

// ===== verif/ir_volume_multi_channel_controller_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for ir_volume_multi_channel_controller_core: directed and random control words
// with a cycle-free level predictor and an in-order result scoreboard. Depends on ivmc_pkg.

module ir_volume_multi_channel_controller_core_tb;

	localparam int CHANS     = 4;
	localparam int PWM_SCALE = 768;
	localparam int DRAIN     = 24;
	localparam int WATCHDOG  = 1000;
	localparam int BURST     = 7;
	localparam logic [2:0] MODE_UNUSED      = 3'd5;
	localparam logic [2:0] MODE_UNUSED_LAST = 3'd7;

	typedef struct {
		logic [2:0]  mode;
		logic [15:0] code;
		logic [15:0] step;
	} ctl_word_t;

	typedef struct {
		logic [1:0]  channel;
		logic [15:0] level;
		logic [9:0]  pwm;
		logic        ring_off;
		logic [1:0]  selected;
		logic        last;
	} lvl_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	wire         s_tready;
	logic [31:0] s_tdata   = '0;
	logic [2:0]  s_tuser   = '0;
	wire         m_tvalid;
	logic        m_tready  = 1'b0;
	wire  [31:0] m_tdata;
	wire  [0:0]  m_tuser;
	wire         m_tlast;

	ctl_word_t   word_q[$];
	ctl_word_t   nxt_word;
	lvl_result_t level_q[$];
	lvl_result_t batch[$];
	lvl_result_t want;
	int          words_queued = 0;
	int          words_sent   = 0;
	int          errors       = 0;
	int          src_idle_pct = 23;
	int          snk_idle_pct = 56;
	bit          word_taken   = 1'b0;

	// predictor copy of registers and state
	logic [2:0]  pot_r  = ivmc_pkg::POT_RESET;
	logic [15:0] base_r = ivmc_pkg::BASE_RESET;
	logic [31:0] dto_r  = ivmc_pkg::DEF_RESET;
	logic [31:0] sto_r  = ivmc_pkg::SHUT_RESET;
	logic [63:0] up_r   = '0;
	logic [63:0] dn_r   = '0;
	logic [63:0] init_r = '0;
	int unsigned lvl_m[CHANS] = '{default: 0};
	int unsigned sel_m     = 0;
	int unsigned step_m    = ivmc_pkg::BASE_RESET;
	int unsigned rpt_m     = 0;
	int unsigned def_left  = 0;
	int unsigned shut_left = 0;
	logic [1:0]  dir_m     = ivmc_pkg::DIR_NONE;
	bit          def_on    = 1'b0;
	bit          shut_on   = 1'b0;

	ir_volume_multi_channel_controller_core #(
		.CHANNELS(CHANS),
		.PWM_FULL_SCALE(PWM_SCALE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata(s_tdata),
		.s_axis_tuser(s_tuser),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_tdata),
		.m_axis_tuser(m_tuser),
		.m_axis_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	function automatic int unsigned chans_in_use();
		return (pot_r < CHANS) ? pot_r : CHANS;
	endfunction

	function automatic int unsigned q15_clip(int unsigned v);
		return (v > ivmc_pkg::Q15_ONE) ? ivmc_pkg::Q15_ONE : v;
	endfunction

	function automatic void emit_level(int unsigned ch, bit off);
		lvl_result_t r;
		int unsigned lv;
		lv = q15_clip(lvl_m[ch]);
		if (batch.size() >= ivmc_pkg::MAX_RES) return;
		r.channel  = 2'(ch);
		r.level    = 16'(lv);
		r.pwm      = 10'((lv * PWM_SCALE + 32'(ivmc_pkg::Q15_ONE) / 2) >> 15);
		r.ring_off = off;
		r.selected = '0;
		r.last     = 1'b0;
		batch = {batch, r};
	endfunction

	function automatic void reload_timers();
		def_left  = dto_r;
		def_on    = 1'b1;
		shut_left = sto_r;
		shut_on   = 1'b1;
	endfunction

	function automatic void nudge_level(int unsigned ch, int inc);
		int v;
		v = int'(q15_clip(lvl_m[ch])) + inc;
		if (v > int'(ivmc_pkg::Q15_ONE)) v = int'(ivmc_pkg::Q15_ONE);
		if (v < 0) v = 0;
		lvl_m[ch] = v;
		if (ch != 0) reload_timers();
		emit_level(ch, 1'b0);
	endfunction

	function automatic void nudge_selected(int inc);
		if (chans_in_use() == 0 || sel_m >= CHANS) return;
		nudge_level(sel_m, inc);
	endfunction

	function automatic int dir_sign();
		if (dir_m == ivmc_pkg::DIR_UP) return 1;
		if (dir_m == ivmc_pkg::DIR_DOWN) return -1;
		return 0;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [63:0] val);
		case (idx)
			ivmc_pkg::REG_POT_COUNT: begin
				pot_r = val[2:0];
				if (sel_m >= chans_in_use()) sel_m = 0;
			end
			ivmc_pkg::REG_BASE_STEP:  base_r = val[15:0];
			ivmc_pkg::REG_DEF_TO:     dto_r  = val[31:0];
			ivmc_pkg::REG_SHUT_TO:    sto_r  = val[31:0];
			ivmc_pkg::REG_UP_CODES:   up_r   = val;
			ivmc_pkg::REG_DOWN_CODES: dn_r   = val;
			ivmc_pkg::REG_INIT_LVL:   init_r = val;
			default: ;
		endcase
	endfunction

	// expected results of one accepted control word, appended to level_q
	function automatic void predict_word(logic [2:0] mode, logic [15:0] code,
			logic signed [15:0] enc);
		int unsigned cnt;
		bit hit;
		logic [1:0] d;
		batch.delete();
		cnt = chans_in_use();
		case (mode)
			ivmc_pkg::MODE_TICK: begin
				if (def_on) begin
					if (def_left <= 1) begin
						def_left = 0;
						def_on   = 1'b0;
						if (cnt > 0) sel_m = 0;
						nudge_selected(0);
					end else begin
						def_left--;
					end
				end
				if (shut_on) begin
					if (shut_left <= 1) begin
						shut_left = 0;
						shut_on   = 1'b0;
						if (cnt > 0 && sel_m < CHANS) emit_level(sel_m, 1'b1);
					end else begin
						shut_left--;
					end
				end
			end
			ivmc_pkg::MODE_IR: begin
				if (code == ivmc_pkg::REPEAT_CODE) begin
					if (rpt_m > 1 && rpt_m % (int'(ivmc_pkg::REPEAT_WRAP) + 1) == 0)
						step_m = q15_clip(step_m + ivmc_pkg::FAST_FACTOR * base_r);
					if (rpt_m < ivmc_pkg::REPEAT_MAX) rpt_m++;
					nudge_selected(int'(q15_clip(step_m)) * dir_sign());
				end else begin
					hit = 1'b0;
					for (int unsigned ch = 0; ch < cnt; ch++) begin
						if (!hit) begin
							d = ivmc_pkg::DIR_NONE;
							if (code == up_r[ch*16 +: 16]) d = ivmc_pkg::DIR_UP;
							else if (code == dn_r[ch*16 +: 16]) d = ivmc_pkg::DIR_DOWN;
							if (d != ivmc_pkg::DIR_NONE) begin
								hit    = 1'b1;
								sel_m  = ch;
								rpt_m  = 0;
								dir_m  = d;
								step_m = q15_clip(base_r);
								nudge_selected(int'(step_m) * dir_sign());
							end
						end
					end
				end
			end
			ivmc_pkg::MODE_ENC: nudge_selected(int'(enc));
			ivmc_pkg::MODE_NEXT: begin
				if (cnt > 0) begin
					sel_m = (sel_m + 1 >= cnt) ? 0 : sel_m + 1;
					nudge_selected(0);
				end
			end
			ivmc_pkg::MODE_START: begin
				for (int unsigned ch = 0; ch < CHANS; ch++)
					lvl_m[ch] = q15_clip(init_r[ch*16 +: 16]);
				sel_m    = 0;
				dir_m    = ivmc_pkg::DIR_NONE;
				rpt_m    = 0;
				step_m   = q15_clip(base_r);
				def_left = dto_r;
				def_on   = 1'b1;
				for (int unsigned ch = 0; ch < cnt; ch++) nudge_level(ch, 0);
			end
			default: ;
		endcase
		foreach (batch[k]) begin
			batch[k].selected = 2'(sel_m);
			batch[k].last     = (k == batch.size() - 1);
			level_q = {level_q, batch[k]};
		end
	endfunction

	task automatic report_err(string msg);
		errors++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic check_field(string name, int got, int exp_val);
		if (got != exp_val)
			report_err($sformatf("%s got %0d want %0d", name, got, exp_val));
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || word_taken)) begin
			if (word_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt_word = word_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {nxt_word.step, nxt_word.code};
				s_tuser  <= nxt_word.mode;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) m_tready <= ($urandom_range(99) >= snk_idle_pct);

	always @(posedge clk) begin
		word_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			predict_word(s_tuser, s_tdata[15:0], s_tdata[31:16]);
			words_sent++;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (level_q.size() == 0) begin
				report_err($sformatf("unexpected result word %h", m_tdata));
			end else begin
				want = level_q.pop_front();
				check_field("channel", m_tdata[1:0], want.channel);
				check_field("level", m_tdata[17:2], want.level);
				check_field("pwm_level", m_tdata[27:18], want.pwm);
				check_field("selected", m_tdata[29:28], want.selected);
				check_field("pad", m_tdata[31:30], 0);
				check_field("ring_off", m_tuser[0], want.ring_off);
				check_field("last", m_tlast, want.last);
			end
		end
	end

	initial begin
		int stall_cnt;
		stall_cnt = 0;
		while (stall_cnt < WATCHDOG) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt = 0;
			else stall_cnt++;
		end
		$display("FAIL ir_volume_multi_channel_controller_core");
		$finish;
	end

	task automatic queue_word(logic [2:0] mode, logic [15:0] code, logic [15:0] step);
		ctl_word_t w;
		w.mode = mode;
		w.code = code;
		w.step = step;
		word_q = {word_q, w};
		words_queued++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		apply_reg(idx, val);
	endtask

	task automatic load_regs(logic [2:0] pot, logic [15:0] base, logic [31:0] dto,
			logic [31:0] sto, logic [63:0] up, logic [63:0] dn, logic [63:0] init);
		write_reg(ivmc_pkg::REG_POT_COUNT, {61'd0, pot});
		write_reg(ivmc_pkg::REG_BASE_STEP, {48'd0, base});
		write_reg(ivmc_pkg::REG_DEF_TO, {32'd0, dto});
		write_reg(ivmc_pkg::REG_SHUT_TO, {32'd0, sto});
		write_reg(ivmc_pkg::REG_UP_CODES, up);
		write_reg(ivmc_pkg::REG_DOWN_CODES, dn);
		write_reg(ivmc_pkg::REG_INIT_LVL, init);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// hold the sender off until every expected word is back and the core has settled
	task automatic wait_idle();
		@(negedge clk);
		while (words_sent != words_queued || level_q.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_timeout(int unsigned hi);
		case ($urandom_range(5))
			0: return '1;
			1: return $urandom;
			default: return $urandom_range(1, hi);
		endcase
	endfunction

	task automatic rand_config();
		logic [2:0]  pot;
		logic [15:0] base;
		logic [31:0] dto, sto;
		logic [63:0] up, dn, init;
		int unsigned r;
		r = $urandom_range(19);
		pot = (r == 0) ? 3'd0 : (r == 1) ? 3'd7 : 3'(1 + r % 4);
		case ($urandom_range(4))
			0: base = '0;
			1: base = ivmc_pkg::Q15_ONE;
			2: base = 16'($urandom_range(1, 2000));
			default: base = 16'($urandom_range(0, 32768));
		endcase
		dto = pick_timeout(6);
		sto = pick_timeout(12);
		for (int lane = 0; lane < CHANS; lane++) begin
			up[lane*16 +: 16] = 16'($urandom);
			dn[lane*16 +: 16] = 16'($urandom);
			init[lane*16 +: 16] = ($urandom_range(7) == 0) ? 16'($urandom_range(32769, 65535))
			                                               : 16'($urandom_range(0, 32768));
		end
		load_regs(pot, base, dto, sto, up, dn, init);
	endtask

	// mostly key press plus repeat runs, mixed with encoder, ticks, select-next, start and noise
	task automatic feed_random(int n);
		int counted;
		int unsigned pick, ch, reps;
		logic [15:0] code;
		counted = 0;
		while (counted < n) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				ch = $urandom_range(CHANS - 1);
				code = $urandom_range(1) ? up_r[ch*16 +: 16] : dn_r[ch*16 +: 16];
				queue_word(ivmc_pkg::MODE_IR, code, 16'($urandom));
				reps = ($urandom_range(9) == 0) ? $urandom_range(20, 24) : $urandom_range(0, 12);
				repeat (reps) queue_word(ivmc_pkg::MODE_IR, ivmc_pkg::REPEAT_CODE, 16'($urandom));
				counted += reps + 1;
			end else if (pick < 45) begin
				code = ($urandom_range(1) == 0) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
				queue_word(ivmc_pkg::MODE_ENC, 16'($urandom),
					$urandom_range(1) ? code : -code);
				counted++;
			end else if (pick < 60) begin
				reps = $urandom_range(1, 4);
				repeat (reps) queue_word(ivmc_pkg::MODE_TICK, 16'($urandom), 16'($urandom));
				counted += reps;
			end else if (pick < 70) begin
				queue_word(ivmc_pkg::MODE_NEXT, 16'($urandom), 16'($urandom));
				counted++;
			end else if (pick < 75) begin
				queue_word(ivmc_pkg::MODE_START, 16'($urandom), 16'($urandom));
				counted++;
			end else if (pick < 85) begin
				queue_word(ivmc_pkg::MODE_IR, 16'($urandom), 16'($urandom));
				counted++;
			end else if (pick < 90) begin
				queue_word(3'($urandom_range(MODE_UNUSED, MODE_UNUSED_LAST)),
					16'($urandom), 16'($urandom));
			end else begin
				queue_word(ivmc_pkg::MODE_IR, ivmc_pkg::REPEAT_CODE, 16'($urandom));
				counted++;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// codes at the field extremes, ch1 up and down equal, ch3 start level oversized
		load_regs(3'd4, ivmc_pkg::BASE_RESET, 32'd2, 32'd3,
			{16'hFFFE, 16'h2002, 16'h1001, 16'h0000},
			{16'h8003, 16'h8002, 16'h1001, 16'h8000},
			{16'hFFFF, 16'h8000, 16'h4000, 16'h0000});
		queue_word(ivmc_pkg::MODE_START, 16'h0000, 16'h0000);
		queue_word(ivmc_pkg::MODE_IR, ivmc_pkg::REPEAT_CODE, 16'h0000);
		queue_word(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
		queue_word(ivmc_pkg::MODE_IR, 16'hFFFE, 16'h0000);
		queue_word(ivmc_pkg::MODE_IR, 16'h8000, 16'h0000);
		queue_word(ivmc_pkg::MODE_ENC, 16'h0000, 16'h7FFF);
		queue_word(ivmc_pkg::MODE_ENC, 16'hFFFF, 16'h8000);
		queue_word(ivmc_pkg::MODE_IR, 16'h1001, 16'h0000);
		queue_word(ivmc_pkg::MODE_NEXT, 16'h0000, 16'h0000);
		queue_word(ivmc_pkg::MODE_IR, 16'h1234, 16'h0000);
		repeat (3) queue_word(ivmc_pkg::MODE_TICK, 16'h0000, 16'h0000);
		wait_idle();

		// repeat run long enough for the step to grow once
		load_regs(3'd4, 16'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, up_r, dn_r, init_r);
		queue_word(ivmc_pkg::MODE_IR, 16'h8002, 16'h0000);
		repeat (11) queue_word(ivmc_pkg::MODE_IR, ivmc_pkg::REPEAT_CODE, 16'h0000);
		wait_idle();

		// selection on ch2 falls outside a single-channel setup
		load_regs(3'd1, ivmc_pkg::Q15_ONE, 32'd1, 32'd1, up_r, dn_r, init_r);
		queue_word(ivmc_pkg::MODE_ENC, 16'h0000, 16'h0005);
		wait_idle();

		// no channels in use
		load_regs(3'd0, 16'd0, 32'd1, 32'd1, up_r, dn_r, init_r);
		queue_word(ivmc_pkg::MODE_START, 16'h0000, 16'h0000);
		queue_word(ivmc_pkg::MODE_ENC, 16'h0000, 16'h0100);
		queue_word(ivmc_pkg::MODE_IR, ivmc_pkg::REPEAT_CODE, 16'h0000);
		queue_word(ivmc_pkg::MODE_TICK, 16'h0000, 16'h0000);
		wait_idle();

		for (int regime = 0; regime < 3; regime++) begin
			case (regime)
				0: begin src_idle_pct = 23; snk_idle_pct = 56; end
				1: begin src_idle_pct = 56; snk_idle_pct = 23; end
				default: begin src_idle_pct = 0; snk_idle_pct = 0; end
			endcase
			for (int p = 0; p < 3; p++) begin
				rand_config();
				feed_random(BURST);
				wait_idle();
			end
		end

		if (errors == 0 && level_q.size() == 0)
			$display("PASS ir_volume_multi_channel_controller_core");
		else
			$display("FAIL ir_volume_multi_channel_controller_core");
		$finish;
	end

endmodule
